/* rtl/lge_pkg.sv */
// Shared types, constants and the generation rule of the life grid engine.
`default_nettype none
package lge_pkg;

  localparam int unsigned GRID_SIZE = 32;
  localparam int unsigned IDX_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned OP_W      = 2;

  localparam int unsigned IN_BITS    = OP_W + 2 * ADDR_W;
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = 1 + OP_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

  typedef logic [GRID_SIZE-1:0] row_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    logic capture;
    logic toggle;
    logic clear;
    logic sweep_load;
    logic sweep_step;
    logic respond;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic sweep_last;
  } dp_stat_t;

  // B3/S23 applied to one row, given the old rows above and below it.
  function automatic row_t next_row(row_t above, row_t cur, row_t below);
    row_t       al, ar, cl, cr, bl, br, fresh;
    logic [3:0] n;
    al = above << 1;
    ar = above >> 1;
    cl = cur << 1;
    cr = cur >> 1;
    bl = below << 1;
    br = below >> 1;
    fresh = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      n = 4'(above[c]) + 4'(al[c]) + 4'(ar[c]) + 4'(cl[c]) + 4'(cr[c])
        + 4'(below[c]) + 4'(bl[c]) + 4'(br[c]);
      fresh[c] = cur[c] ? ((n == SURVIVE_LOW) || (n == SURVIVE_HIGH))
                        : (n == BIRTH_COUNT);
    end
    return fresh;
  endfunction

endpackage
`default_nettype wire

/* rtl/life_grid_engine.sv */
// Top level of the life grid engine: stream ports, controller and datapath.
//
// The block keeps a GRID_SIZE x GRID_SIZE grid of one-bit cells (32 x 32 as
// built), all dead after reset, and runs Conway's Game of Life (B3/S23) on it
// with cells beyond the edges counted as dead and no wrap-around. Each input
// transfer carries an op (advance one generation, toggle a cell, clear the
// grid, read a cell) and a row and column; each op gives exactly one output
// transfer holding the addressed cell's state after the op and an echo of
// the op. A position outside the grid addresses no cell: a toggle there does
// nothing and the reported state is dead. Items are handled one at a time.
// For toggle, clear and read the op is captured, carried out in the EXEC state
// and its result written to the output register in the RESPOND state, after
// which the next input transfer can be taken. An advance adds the generation
// sweep before RESPOND, which rewrites one row per cycle while holding the
// unmodified row above and the current row in a two-row window. The result
// sits in an output register, so a waiting result does not stop the next
// input transfer from being taken; a new result is only written once the old
// one has gone.
`default_nettype none
module life_grid_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // op [1:0], row_index [6:2], col_index [11:7], zero above
  input  wire logic [lge_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // cell_alive [0], done_op [2:1], zero above
  output logic [lge_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import lge_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  op_t      in_op;
  addr_t    in_row;
  addr_t    in_col;
  logic     out_alive;
  op_t      out_op;

  // Unpack the input fields, lowest field first.
  assign in_op  = op_t'(in_tdata[OP_W-1:0]);
  assign in_row = in_tdata[OP_W +: ADDR_W];
  assign in_col = in_tdata[OP_W + ADDR_W +: ADDR_W];

  lge_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lge_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_op),
    .in_row    (in_row),
    .in_col    (in_col),
    .stat      (stat),
    .out_alive (out_alive),
    .out_op    (out_op)
  );

  // Pack the result with the cell state in bit 0 and the echoed op above it.
  assign out_tdata = OUT_DATA_W'({out_op, out_alive});

endmodule
`default_nettype wire

/* rtl/lge_datapath.sv */
// Datapath of the life grid engine: cell grid, sweep row window and result register.
`default_nettype none
module lge_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lge_pkg::dp_cmd_t cmd,
  input  wire lge_pkg::op_t    in_op,
  input  wire lge_pkg::addr_t  in_row,
  input  wire lge_pkg::addr_t  in_col,
  output lge_pkg::dp_stat_t    stat,
  output logic                 out_alive,
  output lge_pkg::op_t         out_op
);
  import lge_pkg::*;

  row_t           grid_r [GRID_SIZE];
  row_t           prev_r;
  row_t           cur_r;
  idx_t           cnt_r;
  op_t            op_r;
  addr_t          row_r;
  addr_t          col_r;
  logic           out_alive_r;
  op_t            out_op_r;

  logic           on_grid;
  logic [IDX_W:0] below_ext;
  logic           below_ok;
  idx_t           rd_idx;
  row_t           rd_row;
  row_t           below_row;
  row_t           fresh;
  logic           alive_nxt;

  always_comb begin
    on_grid   = (32'(row_r) < GRID_SIZE) && (32'(col_r) < GRID_SIZE);
    below_ext = {1'b0, cnt_r} + (IDX_W + 1)'(1);
    below_ok  = 32'(below_ext) < GRID_SIZE;
    if (cmd.sweep_step) begin
      rd_idx = below_ext[IDX_W-1:0];
    end else if (cmd.sweep_load) begin
      rd_idx = '0;
    end else begin
      rd_idx = IDX_W'(row_r);
    end
    rd_row    = grid_r[rd_idx];
    below_row = below_ok ? rd_row : '0;
    fresh     = next_row(prev_r, cur_r, below_row);
    alive_nxt = on_grid & rd_row[IDX_W'(col_r)];
  end

  assign stat.op         = op_r;
  assign stat.sweep_last = (32'(cnt_r) == GRID_SIZE - 1);
  assign out_alive       = out_alive_r;
  assign out_op          = out_op_r;

  // Grid and sweep state; one row is rewritten per sweep cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        grid_r[i] <= '0;
      end
      prev_r <= '0;
      cur_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        grid_r[i] <= '0;
      end
      prev_r <= '0;
    end else if (cmd.toggle) begin
      if (on_grid) begin
        grid_r[IDX_W'(row_r)][IDX_W'(col_r)] <= ~grid_r[IDX_W'(row_r)][IDX_W'(col_r)];
      end
    end else if (cmd.sweep_load) begin
      prev_r <= '0;
      cur_r  <= rd_row;
      cnt_r  <= '0;
    end else if (cmd.sweep_step) begin
      grid_r[cnt_r] <= fresh;
      prev_r        <= cur_r;
      cur_r         <= below_row;
      cnt_r         <= cnt_r + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.respond) begin
      out_alive_r <= alive_nxt;
      out_op_r    <= op_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/lge_ctrl.sv */
// Controller of the life grid engine: op sequencing and result handshake.
`default_nettype none
module lge_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output lge_pkg::dp_cmd_t      cmd,
  input  wire lge_pkg::dp_stat_t stat
);
  import lge_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_RESPOND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  always_comb begin
    in_tready     = (state_r == S_IDLE);
    in_fire       = in_tvalid && in_tready;
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_ADVANCE: begin
            cmd.sweep_load = 1'b1;
            state_nxt      = S_SWEEP;
          end
          OP_TOGGLE: begin
            cmd.toggle = 1'b1;
            state_nxt  = S_RESPOND;
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESPOND;
          end
          default: begin
            state_nxt = S_RESPOND;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_RESPOND;
        end
      end
      S_RESPOND: begin
        if (!out_valid_r || out_tready) begin
          cmd.respond   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while an item is still in progress");

  a_result_from_respond: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESPOND))
    else $error("result presented outside the respond step");

  a_sweep_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (stat.op == OP_ADVANCE))
    else $error("generation sweep running for an op other than advance");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the life grid engine: stream stimulus, cell predictor, checker.
`timescale 1ns / 1ps

module testbench;
  import lge_pkg::*;

  // Rule of the game, written from the textbook statement of B3/S23.
  localparam int BIRTH_NEIGHBOURS = 3;
  localparam int STAY_MIN         = 2;
  localparam int STAY_MAX         = 3;

  // Run shape. The random part ends with the episode in which this many transfers
  // have gone in; the last CALM_ITEMS of them run with no idling on either side.
  localparam int RANDOM_ITEMS  = 1130;
  localparam int CALM_ITEMS    = 150;
  localparam int CHOKE_AT_ITEM = 300;
  localparam int CHOKE_CYCLES  = 250;

  // The tail wait and the bound on waiting for the last results are both
  // multiples of the time an advance takes, the bound much the larger.
  localparam int DRAIN_CYCLES = 4 * (GRID_SIZE + 3);
  localparam int SETTLE_BOUND = 40 * (GRID_SIZE + 3);
  localparam int LIMIT_CYCLES = 400000;

  // One row of the directed table. Where typed is set, the expected cell
  // state is the one written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    op_t   op;
    addr_t row;
    addr_t col;
    logic  typed;
    logic  alive;
  } probe_t;

  // What one output transfer is expected to carry.
  typedef struct packed {
    logic alive;
    op_t  op;
  } cell_report_t;

  localparam int DIRECTED_ROWS = 24;

  // The directed part opens on an empty grid, marks the four corners, lets
  // them die off in isolation, runs a blinker through a full period, and then
  // places a blinker on the top edge to show that nothing wraps to the bottom.
  probe_t directed [DIRECTED_ROWS] = '{
    '{OP_READ,    5'd0,  5'd0,  1'b1, 1'b0},
    '{OP_READ,    5'd31, 5'd31, 1'b1, 1'b0},
    '{OP_ADVANCE, 5'd15, 5'd15, 1'b1, 1'b0},
    '{OP_TOGGLE,  5'd0,  5'd0,  1'b1, 1'b1},
    '{OP_TOGGLE,  5'd0,  5'd31, 1'b1, 1'b1},
    '{OP_TOGGLE,  5'd31, 5'd0,  1'b1, 1'b1},
    '{OP_TOGGLE,  5'd31, 5'd31, 1'b1, 1'b1},
    '{OP_READ,    5'd31, 5'd31, 1'b1, 1'b1},
    '{OP_ADVANCE, 5'd0,  5'd0,  1'b1, 1'b0},
    '{OP_READ,    5'd0,  5'd31, 1'b1, 1'b0},
    '{OP_TOGGLE,  5'd10, 5'd9,  1'b1, 1'b1},
    '{OP_TOGGLE,  5'd10, 5'd10, 1'b1, 1'b1},
    '{OP_TOGGLE,  5'd10, 5'd11, 1'b1, 1'b1},
    '{OP_ADVANCE, 5'd9,  5'd10, 1'b1, 1'b1},
    '{OP_READ,    5'd10, 5'd9,  1'b1, 1'b0},
    '{OP_ADVANCE, 5'd10, 5'd11, 1'b1, 1'b1},
    '{OP_TOGGLE,  5'd10, 5'd10, 1'b1, 1'b0},
    '{OP_TOGGLE,  5'd0,  5'd14, 1'b1, 1'b1},
    '{OP_TOGGLE,  5'd0,  5'd15, 1'b0, 1'b0},
    '{OP_TOGGLE,  5'd0,  5'd16, 1'b0, 1'b0},
    '{OP_ADVANCE, 5'd31, 5'd15, 1'b1, 1'b0},
    '{OP_READ,    5'd1,  5'd15, 1'b0, 1'b0},
    '{OP_CLEAR,   5'd0,  5'd15, 1'b1, 1'b0},
    '{OP_READ,    5'd1,  5'd15, 1'b1, 1'b0}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // op [1:0], row_index [6:2], col_index [11:7], zero above
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // cell_alive [0], done_op [2:1], zero above
  logic [OUT_DATA_W-1:0] out_tdata;

  // Our own copy of the grid: one row per entry, bit c is column c.
  row_t         life_cells [GRID_SIZE];
  cell_report_t cell_reports_due [$];

  int  cycle_count   = 0;
  int  error_count   = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  op_tally [4]  = '{0, 0, 0, 0};
  int  peak_live     = 0;
  bit  calm          = 1'b0;
  bit  sender_gappy  = 1'b1;
  bit  choke_request = 1'b0;

  life_grid_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Reset is held low from the start and then released for good.
  initial begin
    for (int r = 0; r < GRID_SIZE; r++) life_cells[r] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Number of live cells around (r, c); anything off the grid counts as dead.
  function automatic int live_neighbours(int r, int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_SIZE &&
            c + dc >= 0 && c + dc < GRID_SIZE) begin
          n += int'(life_cells[r + dr][c + dc]);
        end
      end
    end
    return n;
  endfunction

  // Applies one op to the grid copy and returns the addressed cell's state
  // afterwards. A generation is computed wholly from the old grid before any
  // row is replaced.
  function automatic logic life_step(input op_t op, input addr_t row, input addr_t col);
    row_t fresh [GRID_SIZE];
    logic on_grid;
    int   n;
    int   live;
    on_grid = (int'(row) < GRID_SIZE) && (int'(col) < GRID_SIZE);
    case (op)
      OP_ADVANCE: begin
        live = 0;
        for (int r = 0; r < GRID_SIZE; r++) begin
          for (int c = 0; c < GRID_SIZE; c++) begin
            n = live_neighbours(r, c);
            fresh[r][c] = life_cells[r][c] ? (n == STAY_MIN || n == STAY_MAX)
                                           : (n == BIRTH_NEIGHBOURS);
            live += int'(fresh[r][c]);
          end
        end
        for (int r = 0; r < GRID_SIZE; r++) life_cells[r] = fresh[r];
        if (live > peak_live) peak_live = live;
      end
      OP_TOGGLE: begin
        if (on_grid) life_cells[row][col] = ~life_cells[row][col];
      end
      OP_CLEAR: begin
        for (int r = 0; r < GRID_SIZE; r++) life_cells[r] = '0;
      end
      default: begin
      end
    endcase
    return on_grid ? life_cells[row][col] : 1'b0;
  endfunction

  // Offers one item on the input stream, waits for its transfer, and then
  // files the result that it should produce. A random gap with valid low
  // may come first; with no gap the valid simply stays high.
  task automatic offer_item(input op_t op, input addr_t row, input addr_t col,
                            input logic typed, input logic typed_alive);
    cell_report_t due;
    logic         predicted;
    if (!calm && sender_gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({col, row, op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = life_step(op, row, col);
    due.alive = typed ? typed_alive : predicted;
    due.op    = op;
    cell_reports_due.push_back(due);
    op_tally[op]++;
    items_sent++;
    if (items_sent == CHOKE_AT_ITEM) choke_request = 1'b1;
    if (items_sent >= DIRECTED_ROWS + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
  endtask

  // A position within span of base, wrapping round the five-bit address so
  // that regions near one edge also reach the cells along the opposite one.
  function automatic addr_t jitter(input addr_t base, input int span);
    return base + addr_t'($urandom_range(0, span));
  endfunction

  // Most episodes seed a small region with toggles and then run it for a few
  // generations, reading cells round about as it evolves. The rest are noise:
  // any op at any position, clears and lone advances included.
  task automatic random_episode();
    int    kind;
    int    span;
    addr_t base_r;
    addr_t base_c;
    kind         = $urandom_range(0, 9);
    sender_gappy = ($urandom_range(0, 2) != 0);
    if (kind < 8) begin
      base_r = addr_t'($urandom_range(0, 31));
      base_c = addr_t'($urandom_range(0, 31));
      span   = $urandom_range(2, 7);
      if ($urandom_range(0, 3) == 0) begin
        offer_item(OP_CLEAR, addr_t'($urandom_range(0, 31)),
                   addr_t'($urandom_range(0, 31)), 1'b0, 1'b0);
      end
      repeat ($urandom_range(4, 18)) begin
        offer_item(OP_TOGGLE, jitter(base_r, span), jitter(base_c, span), 1'b0, 1'b0);
      end
      repeat ($urandom_range(2, 6)) begin
        offer_item(OP_ADVANCE, jitter(base_r, span), jitter(base_c, span), 1'b0, 1'b0);
        repeat ($urandom_range(0, 3)) begin
          offer_item(OP_READ, jitter(base_r, span), jitter(base_c, span), 1'b0, 1'b0);
        end
      end
    end else begin
      repeat ($urandom_range(5, 15)) begin
        offer_item(op_t'($urandom_range(0, 3)), addr_t'($urandom_range(0, 31)),
                   addr_t'($urandom_range(0, 31)), 1'b0, 1'b0);
      end
    end
  endtask

  // Receiver. It stalls in short random bursts, now and then keeps tready
  // high for a quiet stretch, and once holds off for a long while so that
  // the engine's output register fills and the input stream backs up.
  initial begin : receiver
    int quiet_left;
    quiet_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (choke_request) begin
        choke_request = 1'b0;
        out_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else if (!calm && quiet_left == 0 && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 3) == 0) quiet_left = $urandom_range(20, 80);
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        if (quiet_left > 0) quiet_left--;
        @(posedge clk);
      end
    end
  end

  // Every output transfer is matched against the oldest filed result.
  always @(posedge clk) begin
    cell_report_t due;
    logic         got_alive;
    op_t          got_op;
    if (rst_n && out_tvalid && out_tready) begin
      got_alive = out_tdata[0];
      got_op    = op_t'(out_tdata[2:1]);
      results_seen++;
      if (cell_reports_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing outstanding (op %0d)",
                                results_seen, got_op));
      end else begin
        due = cell_reports_due.pop_front();
        if (got_alive !== due.alive) begin
          flag_mismatch($sformatf("result %0d cell_alive after %s: got %b, expected %b",
                                  results_seen, due.op.name(), got_alive, due.alive));
        end
        if (got_op !== due.op) begin
          flag_mismatch($sformatf("result %0d done_op: got %0d, expected %0d",
                                  results_seen, got_op, due.op));
        end
      end
    end
  end

  // Main sequence: the directed table, the random episodes, then the drain.
  initial begin : stimulus
    int waited;
    while (!rst_n) @(posedge clk);
    @(posedge clk);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_item(directed[i].op, directed[i].row, directed[i].col,
                 directed[i].typed, directed[i].alive);
    end
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) random_episode();
    in_tvalid <= 1'b0;

    // Let the outstanding results come home, then give the engine the drain
    // wait in case anything stray follows them.
    waited = 0;
    while (cell_reports_due.size() != 0 && waited < SETTLE_BOUND) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cell_reports_due.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", cell_reports_due.size()));
    end

    $display("Run covered %0d transfers in: %0d advances, %0d toggles, %0d clears, %0d reads.",
             items_sent, op_tally[OP_ADVANCE], op_tally[OP_TOGGLE], op_tally[OP_CLEAR],
             op_tally[OP_READ]);
    $display("Peak live population %0d cells, one %0d-cycle output hold-off, %0d mismatches.",
             peak_live, CHOKE_CYCLES, error_count);
    if (error_count == 0) begin
      $display("life_grid_engine test passed");
    end else begin
      $display("life_grid_engine test failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("Watchdog expired after %0d cycles.", cycle_count);
    $display("life_grid_engine test failed");
    $finish;
  end

endmodule
